// ----- rtl/bdq_pkg.sv -----
package bdq_pkg;

    localparam int DEPTH      = 1024;
    localparam int WORD_BITS  = 32;
    localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int SUM_BITS   = ADDR_BITS + 1;

    localparam int OPCODE_BITS = 3;
    localparam int DATA_BITS   = 32;
    localparam int INDEX_BITS  = 10;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 11;
    localparam int CMP_BITS    = (INDEX_BITS > CNT_BITS) ? INDEX_BITS : CNT_BITS;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ       = 3'd4
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        logic [WORD_BITS-1:0] wdata;
        logic                 re;
        logic [ADDR_BITS-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic                  valid;
        status_t               status;
        logic [CNT_BITS-1:0]   count;
        logic                  from_mem;
    } result_t;

endpackage

// ----- rtl/bdq_ram.sv -----
module bdq_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W) - 1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bdq_ctrl.sv -----
module bdq_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [bdq_pkg::OPCODE_BITS-1:0]     opcode,
    input  logic [bdq_pkg::DATA_BITS-1:0]       data_in,
    input  logic [bdq_pkg::INDEX_BITS-1:0]      index,
    output bdq_pkg::mem_req_t                   mem_req,
    output bdq_pkg::result_t                    result
);

    logic [bdq_pkg::ADDR_BITS-1:0] head_reg;
    logic [bdq_pkg::ADDR_BITS-1:0] head_next;
    logic [bdq_pkg::CNT_BITS-1:0]  count_reg;
    logic [bdq_pkg::CNT_BITS-1:0]  count_next;
    bdq_pkg::result_t              result_reg;
    bdq_pkg::result_t              result_next;

    logic                          full;
    logic                          empty;
    logic                          in_range;
    logic [bdq_pkg::CNT_BITS-1:0]  offset;
    logic [bdq_pkg::SUM_BITS-1:0]  sum;
    logic [bdq_pkg::ADDR_BITS-1:0] slot;
    logic [bdq_pkg::ADDR_BITS-1:0] head_dec;
    logic [bdq_pkg::ADDR_BITS-1:0] head_inc;
    logic [bdq_pkg::SUM_BITS-1:0]  head_inc_wide;

    assign full     = (count_reg == bdq_pkg::CNT_BITS'(bdq_pkg::DEPTH));
    assign empty    = (count_reg == '0);
    assign in_range = (bdq_pkg::CMP_BITS'(index) < bdq_pkg::CMP_BITS'(count_reg));

    always_comb
    begin
        case (bdq_pkg::op_t'(opcode))
            bdq_pkg::OP_POP_BACK:  offset = count_reg - 1'b1;
            bdq_pkg::OP_READ:      offset = bdq_pkg::CNT_BITS'(index);
            default:               offset = count_reg;
        endcase
    end

    assign sum  = bdq_pkg::SUM_BITS'(head_reg) + bdq_pkg::SUM_BITS'(offset);
    assign slot = (sum >= bdq_pkg::SUM_BITS'(bdq_pkg::DEPTH))
                  ? bdq_pkg::ADDR_BITS'(sum - bdq_pkg::SUM_BITS'(bdq_pkg::DEPTH))
                  : bdq_pkg::ADDR_BITS'(sum);

    assign head_dec = (head_reg == '0) ? bdq_pkg::ADDR_BITS'(bdq_pkg::DEPTH - 1)
                                       : head_reg - 1'b1;
    assign head_inc_wide = bdq_pkg::SUM_BITS'(head_reg) + 1'b1;
    assign head_inc = (head_inc_wide == bdq_pkg::SUM_BITS'(bdq_pkg::DEPTH))
                      ? '0 : bdq_pkg::ADDR_BITS'(head_inc_wide);

    always_comb
    begin
        head_next            = head_reg;
        count_next           = count_reg;
        mem_req.we           = 1'b0;
        mem_req.waddr        = slot;
        mem_req.wdata        = bdq_pkg::WORD_BITS'(data_in);
        mem_req.re           = 1'b0;
        mem_req.raddr        = slot;
        result_next.valid    = accept;
        result_next.status   = bdq_pkg::ST_OK;
        result_next.from_mem = 1'b0;
        if (accept)
        begin
            case (bdq_pkg::op_t'(opcode))
                bdq_pkg::OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        result_next.status = bdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_req.we = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                bdq_pkg::OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        result_next.status = bdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = head_dec;
                        head_next     = head_dec;
                        count_next    = count_reg + 1'b1;
                    end
                end
                bdq_pkg::OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        result_next.status = bdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        mem_req.re           = 1'b1;
                        result_next.from_mem = 1'b1;
                        count_next           = count_reg - 1'b1;
                    end
                end
                bdq_pkg::OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        result_next.status = bdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        mem_req.re           = 1'b1;
                        mem_req.raddr        = head_reg;
                        result_next.from_mem = 1'b1;
                        head_next            = head_inc;
                        count_next           = count_reg - 1'b1;
                    end
                end
                bdq_pkg::OP_READ:
                begin
                    if (!in_range)
                    begin
                        result_next.status = bdq_pkg::ST_RANGE;
                    end
                    else
                    begin
                        mem_req.re           = 1'b1;
                        result_next.from_mem = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        result_next.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            result_reg <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- rtl/bounded_deque_with_indexed_read.sv -----
// Channel   Ports                          Transfer
// command   start, opcode, data_in, index  start high while busy low
// result    done, data_out, status, count  done high for one cycle
//
// Each command gives its result in the cycle after the transfer, one command per cycle.
// That delay is the registered read of the entry memory.
// busy stays low: a push written in one cycle is visible to a read in the next.
// Reset clears the head pointer and the count; memory contents stay undefined.
// The receiver cannot stall, so every result is delivered on the cycle it appears.
module bounded_deque_with_indexed_read (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bdq_pkg::OPCODE_BITS-1:0]     opcode,
    input  logic [bdq_pkg::DATA_BITS-1:0]       data_in,
    input  logic [bdq_pkg::INDEX_BITS-1:0]      index,
    output logic                                done,
    output logic [bdq_pkg::DATA_BITS-1:0]       data_out,
    output logic [bdq_pkg::STATUS_BITS-1:0]     status,
    output logic [bdq_pkg::COUNT_BITS-1:0]      count
);

    bdq_pkg::mem_req_t              mem_req;
    bdq_pkg::result_t               result;
    logic [bdq_pkg::WORD_BITS-1:0]  rdata;
    logic                           accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    bdq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .opcode  (opcode),
        .data_in (data_in),
        .index   (index),
        .mem_req (mem_req),
        .result  (result)
    );

    bdq_ram #(
        .ADDR_W (bdq_pkg::ADDR_BITS),
        .DATA_W (bdq_pkg::WORD_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    assign done     = result.valid;
    assign data_out = result.from_mem ? bdq_pkg::DATA_BITS'(rdata) : '0;
    assign status   = result.status;
    assign count    = bdq_pkg::COUNT_BITS'(result.count);

endmodule

// ----- rtl/bdq_checker.sv -----
module bdq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic [bdq_pkg::DATA_BITS-1:0]       data_out,
    input logic [bdq_pkg::STATUS_BITS-1:0]     status,
    input logic [bdq_pkg::COUNT_BITS-1:0]      count
);

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("Accepted command gave no result.");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("Result without a command transfer.");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != bdq_pkg::ST_OK) |-> (data_out == '0))
        else $error("Nonzero data on an error result.");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bdq_pkg::ST_EMPTY) |-> (count == '0))
        else $error("Empty status with a nonzero count.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bdq_pkg::ST_FULL)
            |-> (count == bdq_pkg::COUNT_BITS'(bdq_pkg::DEPTH)))
        else $error("Full status while the queue is not full.");

endmodule

bind bounded_deque_with_indexed_read bdq_checker u_bdq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .data_out (data_out),
    .status   (status),
    .count    (count)
);
